FILE: rtl/rgn_pkg.sv
// Shared types, constants and helper functions for the region owner map.
`timescale 1ns / 1ps

package rgn_pkg;

  localparam int ADDR_W           = 47;
  localparam int LEN_W            = 48;
  localparam int OWNER_W          = 47;
  localparam int GEN_W            = 64;
  localparam int CMD_W            = 2;
  localparam int REGION_SHIFT     = 21;
  localparam int TABLE_INDEX_BITS = 10;
  // Wide enough for base + length - 1 without overflow.
  localparam int SPAN_W           = LEN_W + 1;

  typedef logic [TABLE_INDEX_BITS-1:0] idx_t;
  typedef logic [OWNER_W-1:0]          owner_t;
  typedef logic [SPAN_W-1:0]           span_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // One access to the owner table: a write port and a read port.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    owner_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  // Result hand-off from the sequencer to the output register.
  typedef struct packed {
    logic fire;
    logic lookup;
  } res_t;

  // True when the byte address falls in a region covered by the table.
  function automatic logic in_table(input span_t addr);
    span_t reg_no;
    reg_no = addr >> (REGION_SHIFT + TABLE_INDEX_BITS);
    return (reg_no == '0);
  endfunction

  // Table index of the region holding the byte address.
  function automatic idx_t region_idx(input span_t addr);
    span_t reg_no;
    reg_no = addr >> REGION_SHIFT;
    return reg_no[TABLE_INDEX_BITS-1:0];
  endfunction

endpackage

FILE: rtl/region_owner_map.sv
// Top level of the region owner map: sequencer, owner table and output register.
//
// The block keeps one owner word for each of the first 2^TABLE_INDEX_BITS address
// regions of 2^REGION_SHIFT bytes. Commands arrive on the input channel (in_valid,
// in_stall; fields cmd, address, length, owner_in) and each transaction gives exactly
// one result transaction on the output channel (out_valid, out_stall; fields
// owner_out, generation). A transaction is accepted on a rising edge with valid high
// and stall low.
// A lookup reads the table memory on acceptance; the result state passes the read
// data to the output register. An insert or remove writes its regions one by one,
// then enters the result state; a range starting outside the table, or of zero
// length, goes straight there. The single write port of the table sets the pace of
// range fills. One transaction is worked on at a time; the next may be accepted while
// the previous result still waits in the output register.
// After reset the table is swept to zero, one entry per cycle, over all
// 2^TABLE_INDEX_BITS (1024) entries, and in_stall stays high during the sweep. The
// generation count starts at zero.
// If the receiver holds out_stall, the result stays in the output register, the next
// result waits in the result state, and a further transaction stalls on input.
`timescale 1ns / 1ps

module region_owner_map (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rgn_pkg::CMD_W-1:0]   cmd,
  input  logic [rgn_pkg::ADDR_W-1:0]  address,
  input  logic [rgn_pkg::LEN_W-1:0]   length,
  input  logic [rgn_pkg::OWNER_W-1:0] owner_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rgn_pkg::OWNER_W-1:0] owner_out,
  output logic [rgn_pkg::GEN_W-1:0]   generation
);

  rgn_pkg::mem_req_t mem_req;
  rgn_pkg::res_t     res;
  rgn_pkg::owner_t   rdata;
  logic              out_free;
  logic              accept;
  logic [rgn_pkg::GEN_W-1:0] gen_count;

  // The output register can take a new result when empty or being emptied.
  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  rgn_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .address  (address),
    .length   (length),
    .owner_in (owner_in),
    .out_free (out_free),
    .mem_req  (mem_req),
    .res      (res)
  );

  rgn_table u_table (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Every remove bumps the generation, whether or not it writes any region. It is
  // updated at acceptance, before the result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_count <= '0;
    end else if (accept && cmd == rgn_pkg::CMD_REMOVE) begin
      gen_count <= gen_count + rgn_pkg::GEN_W'(1);
    end
  end

  // Output register. A lookup outside the table, and every other command, answers 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      owner_out  <= res.lookup ? rdata : '0;
      generation <= gen_count;
    end
  end

  // The generation moves by at most one per cycle.
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (gen_count == $past(gen_count) ||
                     gen_count == $past(gen_count) + rgn_pkg::GEN_W'(1)))
    else $error("generation count jumped");

endmodule

FILE: rtl/rgn_table.sv
// Owner table: synchronous memory with one write port and one registered read port.
`timescale 1ns / 1ps

module rgn_table (
  input  logic              clk,
  input  rgn_pkg::mem_req_t req,
  output rgn_pkg::owner_t   rdata
);

  localparam int DEPTH = 1 << rgn_pkg::TABLE_INDEX_BITS;

  rgn_pkg::owner_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/rgn_seq.sv
// Sequencer: clearing pass, lookups and region-by-region range fills.
`timescale 1ns / 1ps

module rgn_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rgn_pkg::CMD_W-1:0]   cmd,
  input  logic [rgn_pkg::ADDR_W-1:0]  address,
  input  logic [rgn_pkg::LEN_W-1:0]   length,
  input  logic [rgn_pkg::OWNER_W-1:0] owner_in,
  input  logic                        out_free,
  output rgn_pkg::mem_req_t           mem_req,
  output rgn_pkg::res_t               res
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_FILL   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t          state, state_next;
  rgn_pkg::idx_t   cur, cur_next;
  rgn_pkg::idx_t   last, last_next;
  rgn_pkg::owner_t fill_val, fill_val_next;
  logic            lookup, lookup_next;

  logic            accept;
  rgn_pkg::span_t  base;
  rgn_pkg::span_t  end_addr;
  logic            len_zero;
  logic            first_in;
  rgn_pkg::idx_t   last_idx;

  assign accept   = in_valid && (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);

  assign base     = rgn_pkg::SPAN_W'(address);
  assign end_addr = base + rgn_pkg::SPAN_W'(length) - rgn_pkg::SPAN_W'(1);
  assign len_zero = (length == '0);
  assign first_in = rgn_pkg::in_table(base);
  assign last_idx = rgn_pkg::in_table(end_addr) ? rgn_pkg::region_idx(end_addr) : '1;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    last_next     = last;
    fill_val_next = fill_val;
    lookup_next   = lookup;
    mem_req       = '0;
    res           = '0;
    unique case (state)
      ST_CLEAR, ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur;
        mem_req.wdata = fill_val;
        cur_next      = cur + rgn_pkg::idx_t'(1);
        if (cur == last) begin
          state_next = (state == ST_CLEAR) ? ST_IDLE : ST_RESULT;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          lookup_next = 1'b0;
          state_next  = ST_RESULT;
          if (cmd == rgn_pkg::CMD_LOOKUP) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = rgn_pkg::region_idx(base);
            lookup_next   = first_in;
          end else if ((cmd == rgn_pkg::CMD_INSERT || cmd == rgn_pkg::CMD_REMOVE) &&
                       !len_zero && first_in) begin
            cur_next      = rgn_pkg::region_idx(base);
            last_next     = last_idx;
            fill_val_next = (cmd == rgn_pkg::CMD_INSERT) ? owner_in : '0;
            state_next    = ST_FILL;
          end
        end
      end
      ST_RESULT: begin
        res.lookup = lookup;
        if (out_free) begin
          res.fire   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cur      <= '0;
      last     <= '1;
      fill_val <= '0;
      lookup   <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      last     <= last_next;
      fill_val <= fill_val_next;
      lookup   <= lookup_next;
    end
  end

  // A fill walks upwards and stops at its last region.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (cur <= last))
    else $error("fill index passed the end of its range");

  // The clearing pass hands over to idle once the last entry is written.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && cur == last) |=> (state == ST_IDLE))
    else $error("clearing pass did not finish");

  // A lookup always has its read data in the following cycle, in the result state.
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == rgn_pkg::CMD_LOOKUP) |=> (state == ST_RESULT && $past(mem_req.re)))
    else $error("lookup did not reach the result state");

  // Table writes and reads never come during the result hand-off.
  assert property (@(posedge clk) disable iff (rst)
    res.fire |-> !mem_req.we && !mem_req.re)
    else $error("table access during result hand-off");

endmodule
